// ----- rtl/ppt_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ppt_pkg: shared types and constants of the page table translation block
// Field widths, table geometry and the request and status codes.
// ============================================================================
package ppt_pkg;

    // Table geometry.
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths.
    localparam int PID_W   = 16;
    localparam int PAGE_W  = 20;
    localparam int VA_W    = 31;
    localparam int PS_W    = 17;
    localparam int PA_W    = 22;
    localparam int STAT_W  = 2;
    localparam int DCNT_W  = $clog2(VA_W);

    // Stream payload widths, padded to whole bytes.
    localparam int S_DATA_W = ((PID_W + PAGE_W + VA_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((IDX_W + PA_W + 7) / 8) * 8;
    localparam int M_USER_W = STAT_W + 1;

    localparam logic [PS_W-1:0] PAGE_BYTES_RST = PS_W'(4096);

    // Request kinds.
    localparam logic REQ_MAP       = 1'b0;
    localparam logic REQ_TRANSLATE = 1'b1;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_NEW  = 2'd0;
    localparam logic [STAT_W-1:0] ST_OLD  = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd3;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    // Divider handshake seen from the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- rtl/ppt_divider.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ppt_divider: iterative restoring divider
// Produces one quotient bit per cycle by a shared subtract and compare.
// ============================================================================
module ppt_divider
    import ppt_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [VA_W-1:0]  i_dividend,
    input  logic [PS_W-1:0]  i_divisor,
    output t_div_stat        o_stat,
    output logic [VA_W-1:0]  o_quotient,
    output logic [PS_W-1:0]  o_remainder
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DCNT_W-1:0] r_cnt, n_cnt;
    logic [VA_W-1:0]   r_quo, n_quo;
    logic [PS_W-1:0]   r_rem, n_rem;
    logic [PS_W-1:0]   r_div, n_div;
    logic [PS_W:0]     trial;
    logic [PS_W:0]     diff;

    // The trial remainder is one bit wider than the divisor.
    assign trial = {r_rem, r_quo[VA_W-1]};
    assign diff  = trial - {1'b0, r_div};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_div  = r_div;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DCNT_W'(VA_W - 1);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_div  = i_divisor;
        end else if (r_busy) begin
            if (trial >= {1'b0, r_div}) begin
                n_rem = diff[PS_W-1:0];
                n_quo = {r_quo[VA_W-2:0], 1'b1};
            end else begin
                n_rem = trial[PS_W-1:0];
                n_quo = {r_quo[VA_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

// ----- rtl/ppt_key_ram.sv -----
`timescale 1ns / 1ps
// ============================================================================
// ppt_key_ram: key store of the page table
// One write port and one registered read port for the pid and page of each frame.
// ============================================================================
module ppt_key_ram
    import ppt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [IDX_W-1:0]  i_waddr,
    input  logic [PID_W-1:0]  i_wpid,
    input  logic [PAGE_W-1:0] i_wpage,
    input  logic [IDX_W-1:0]  i_raddr,
    output logic [PID_W-1:0]  o_rpid,
    output logic [PAGE_W-1:0] o_rpage
);

    logic [PID_W+PAGE_W-1:0] r_mem [ENTRIES];
    logic [PID_W+PAGE_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wpid, i_wpage};
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rpid  = r_rdata[PID_W+PAGE_W-1:PAGE_W];
    assign o_rpage = r_rdata[PAGE_W-1:0];

endmodule

// ----- rtl/pid_page_table_translate.sv -----
`timescale 1ns / 1ps
// ============================================================================
// pid_page_table_translate: pid-tagged page table with address translation
// Maps (pid, page) keys to frames and translates virtual addresses.
// ============================================================================
// Usage. Requests enter on the s_axis channel: tuser selects map (0) or
// translate (1), tdata carries pid, page number and virtual address. Every
// request yields exactly one response on the m_axis channel: tuser carries
// status and hit, tdata carries frame number and physical address.
// Frames are handed out in order and never freed, so an entry is valid
// exactly when its index is below the count of used frames.
// Timing. The block works on one request at a time and s_axis_tready is high
// only while the sequencer is idle. A map request scans the key memory one
// entry per cycle through its registered read port. A translate request first
// runs the iterative divider to split the address into page number and offset,
// then the same scan.
// Stalls. A finished response sits in the output register until m_axis_tready
// takes it; the next request is still accepted meanwhile and waits for the
// output register only at its end. Reset clears the frame count (emptying the
// table), the sequencer and the output valid, and sets the page size to 4096.
// The page size port may be written only while the block is idle.
// ============================================================================
module pid_page_table_translate
    import ppt_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Page size register write port.
    input  logic                i_cfg_we,
    input  logic [PS_W-1:0]     i_cfg_wdata,
    // Request channel.
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata: pid [15:0], vpage [35:16], vaddr [66:36], zero pad.
    input  logic [S_DATA_W-1:0] s_axis_tdata,
    // tuser: req_type.
    input  logic                s_axis_tuser,
    // Response channel.
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata: frame_number [5:0], physical_address [27:6], zero pad.
    output logic [M_DATA_W-1:0] m_axis_tdata,
    // tuser: status [1:0], hit [2].
    output logic [M_USER_W-1:0] m_axis_tuser
);

    // Configuration and table state.
    logic [PS_W-1:0]   r_page_bytes;
    logic [CNT_W-1:0]  r_frames_used, n_frames_used;

    // Sequencer and request context.
    t_state            r_state, n_state;
    logic              r_req, n_req;
    logic [PID_W-1:0]  r_pid, n_pid;
    logic [PAGE_W-1:0] r_key_page, n_key_page;
    logic [VA_W-1:0]   r_va, n_va;
    logic [PS_W-1:0]   r_off, n_off;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_pend, n_pend;
    logic              r_found, n_found;
    logic [IDX_W-1:0]  r_frame, n_frame;

    // Output register.
    logic              r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    logic              r_out_hit, n_out_hit;
    logic [IDX_W-1:0]  r_out_frame, n_out_frame;
    logic [PA_W-1:0]   r_out_phys, n_out_phys;

    // Datapath signals.
    logic [PS_W-1:0]       ps_eff;
    logic                  div_start;
    t_div_stat             div_stat;
    logic [VA_W-1:0]       div_quo;
    logic [PS_W-1:0]       div_rem;
    logic                  ram_we;
    logic [PID_W-1:0]      ram_pid;
    logic [PAGE_W-1:0]     ram_page;
    logic [IDX_W+PS_W-1:0] frame_base;
    logic [IDX_W+PS_W:0]   phys_sum;
    logic                  key_match;
    logic                  table_full;

    // A zero page size behaves as a page of one byte.
    assign ps_eff = (r_page_bytes == '0) ? PS_W'(1) : r_page_bytes;

    ppt_divider u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (r_va),
        .i_divisor   (ps_eff),
        .o_stat      (div_stat),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    ppt_key_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_frames_used[IDX_W-1:0]),
        .i_wpid  (r_pid),
        .i_wpage (r_key_page),
        .i_raddr (r_idx[IDX_W-1:0]),
        .o_rpid  (ram_pid),
        .o_rpage (ram_page)
    );

    assign key_match  = (ram_pid == r_pid) && (ram_page == r_key_page);
    assign table_full = (r_frames_used >= CNT_W'(ENTRIES));

    // Translation result: frame scaled by page size plus the page offset,
    // wrapped to the physical address width.
    assign frame_base = r_frame * ps_eff;
    assign phys_sum   = {1'b0, frame_base} + (IDX_W + PS_W + 1)'(r_off);

    always_comb begin
        n_state       = r_state;
        n_req         = r_req;
        n_pid         = r_pid;
        n_key_page    = r_key_page;
        n_va          = r_va;
        n_off         = r_off;
        n_idx         = r_idx;
        n_pend        = r_pend;
        n_found       = r_found;
        n_frame       = r_frame;
        n_frames_used = r_frames_used;
        n_out_valid   = r_out_valid && !m_axis_tready;
        n_out_status  = r_out_status;
        n_out_hit     = r_out_hit;
        n_out_frame   = r_out_frame;
        n_out_phys    = r_out_phys;
        div_start     = 1'b0;
        ram_we        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_req      = s_axis_tuser;
                    n_pid      = s_axis_tdata[PID_W-1:0];
                    n_key_page = s_axis_tdata[PID_W+PAGE_W-1:PID_W];
                    n_va       = s_axis_tdata[PID_W+PAGE_W+VA_W-1:PID_W+PAGE_W];
                    n_off      = '0;
                    n_idx      = '0;
                    n_pend     = 1'b0;
                    n_found    = 1'b0;
                    n_frame    = '0;
                    n_state    = (s_axis_tuser == REQ_MAP) ? S_SCAN : S_DIV;
                end
            end
            S_DIV: begin
                // The divider starts on the first cycle here, once r_va holds.
                if (!div_stat.busy && !div_stat.done && r_idx == '0 && !r_pend) begin
                    div_start = 1'b1;
                    n_pend    = 1'b1;
                end else if (div_stat.done) begin
                    n_pend     = 1'b0;
                    n_key_page = div_quo[PAGE_W-1:0];
                    n_off      = div_rem;
                    // A page number beyond the key width can never match.
                    n_state    = (div_quo[VA_W-1:PAGE_W] != '0) ? S_DONE : S_SCAN;
                end
            end
            S_SCAN: begin
                // Reads are issued one per cycle; the data of the previous
                // read is compared while the next address goes out.
                if (r_pend && key_match) begin
                    n_found = 1'b1;
                    n_frame = IDX_W'(r_idx - 1'b1);
                    n_pend  = 1'b0;
                    n_state = S_DONE;
                end else if (r_idx < r_frames_used) begin
                    n_idx  = r_idx + 1'b1;
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_hit    = 1'b0;
                    n_out_frame  = '0;
                    n_out_phys   = '0;
                    if (r_req == REQ_MAP) begin
                        if (r_found) begin
                            n_out_status = ST_OLD;
                            n_out_frame  = r_frame;
                        end else if (table_full) begin
                            n_out_status = ST_FULL;
                        end else begin
                            n_out_status  = ST_NEW;
                            n_out_frame   = r_frames_used[IDX_W-1:0];
                            ram_we        = 1'b1;
                            n_frames_used = r_frames_used + 1'b1;
                        end
                    end else if (r_found) begin
                        n_out_status = ST_NEW;
                        n_out_hit    = 1'b1;
                        n_out_frame  = r_frame;
                        n_out_phys   = phys_sum[PA_W-1:0];
                    end else begin
                        n_out_status = ST_MISS;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_page_bytes  <= PAGE_BYTES_RST;
            r_frames_used <= '0;
            r_out_valid   <= 1'b0;
            r_idx         <= '0;
            r_pend        <= 1'b0;
            r_found       <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_frames_used <= n_frames_used;
            r_out_valid   <= n_out_valid;
            r_idx         <= n_idx;
            r_pend        <= n_pend;
            r_found       <= n_found;
            if (i_cfg_we) begin
                r_page_bytes <= i_cfg_wdata;
            end
        end
        r_req        <= n_req;
        r_pid        <= n_pid;
        r_key_page   <= n_key_page;
        r_va         <= n_va;
        r_off        <= n_off;
        r_frame      <= n_frame;
        r_out_status <= n_out_status;
        r_out_hit    <= n_out_hit;
        r_out_frame  <= n_out_frame;
        r_out_phys   <= n_out_phys;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_DATA_W'({r_out_phys, r_out_frame});
    assign m_axis_tuser  = {r_out_hit, r_out_status};

    // The frame count never passes the table size.
    a_frames_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_frames_used <= CNT_W'(ENTRIES))
        else $error("frame count beyond table size");

    // A table-full response is only given when every frame is used.
    a_full_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[STAT_W-1:0] == ST_FULL) |-> table_full)
        else $error("table full reported with free frames");

    // A hit always carries the success status.
    a_hit_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[STAT_W]) |-> (m_axis_tuser[STAT_W-1:0] == ST_NEW))
        else $error("hit with non-success status");

    // The scan pointer never runs past the used frames.
    a_scan_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_frames_used))
        else $error("scan pointer beyond used frames");

    // The frame count only grows while a map response is produced.
    a_count_on_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_frames_used != $past(r_frames_used)) |->
            ($past(r_state) == S_DONE && $past(r_req) == REQ_MAP))
        else $error("frame count changed outside a map request");

endmodule
